// File: rtl/lmfr_pkg.sv
package lmfr_pkg;

  // command codes
  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_REFRESH = 3'd1;
  localparam logic [2:0] CMD_SCROLL  = 3'd2;
  localparam logic [2:0] CMD_WRITE   = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  typedef logic [3:0] cfg_data_t;
  localparam cfg_idx_t CFG_BRIGHTNESS = 1'd0;
  localparam cfg_idx_t CFG_SCAN_LIMIT = 1'd1;

  // init phases
  localparam logic [2:0] PH_SHUTDOWN = 3'd0;
  localparam logic [2:0] PH_CLEAR    = 3'd1;
  localparam logic [2:0] PH_DECODE   = 3'd2;
  localparam logic [2:0] PH_SCAN     = 3'd3;
  localparam logic [2:0] PH_BRIGHT   = 3'd4;
  localparam logic [2:0] PH_COPY     = 3'd5;
  localparam logic [2:0] PH_WAKE     = 3'd6;

  // driver command words
  localparam logic [15:0] W_SHUTDOWN   = 16'h0C00;
  localparam logic [15:0] W_WAKE       = 16'h0C01;
  localparam logic [15:0] W_DECODE_OFF = 16'h0900;
  localparam logic [15:0] W_SCAN       = 16'h0B00;
  localparam logic [15:0] W_BRIGHT     = 16'h0A00;

  localparam logic [3:0] BRIGHTNESS_RST = 4'd0;
  localparam logic [2:0] SCAN_LIMIT_RST = 3'd7;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

// File: rtl/lmfr_intf.sv
interface lmfr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [3:0]  row;
  logic [31:0] row_data;
  logic [7:0]  amount;

  modport source (output valid, cmd, row, row_data, amount, input ready);
  modport sink (input valid, cmd, row, row_data, amount, output ready);
endinterface

interface lmfr_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] spi_word;
  logic        spi_valid;
  logic        last_word;
  logic        sequence_done;
  logic [31:0] read_value;
  logic        row_ok;

  modport source (output valid, spi_word, spi_valid, last_word, sequence_done, read_value,
                  row_ok, input ready);
  modport sink (input valid, spi_word, spi_valid, last_word, sequence_done, read_value,
                row_ok, output ready);
endinterface

// File: rtl/led_matrix_frame_refresher_unit.sv
// Frame refresher for a chain of MODULES cascaded 8x8 LED driver chips. The frame buffer
// (ROWS rows of 8*MODULES bits) sits in a small RAM with a registered read; a per-row
// valid bit makes every row read as zero after reset. A request is taken only while the
// block is idle; a request that sends words (init step, refresh step) then puts out
// MODULES words, one per cycle while the sink keeps taking them. Write row and read row
// give one result each, a silent init step gives none, and scroll walks the buffer one
// row per cycle through the RAM's single read and write ports. The output register lets
// the last word of a request wait for the sink while the next request is already taken.
// Configuration writes (brightness, scan limit) land directly in flops and are meant for
// an idle block.
module led_matrix_frame_refresher_unit #(
  parameter int ROWS    = 8,
  parameter int MODULES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lmfr_req_if.sink            req_i,
  lmfr_rsp_if.source          rsp_o,
  input  logic                cfg_we_i,
  input  lmfr_pkg::cfg_idx_t  cfg_idx_i,
  input  lmfr_pkg::cfg_data_t cfg_data_i
);

  import lmfr_pkg::*;

  localparam int RowBits = 8 * MODULES;
  localparam int AddrW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ClrW    = $clog2(ROWS + 1);
  localparam int ModW    = (MODULES > 1) ? $clog2(MODULES) : 1;

  localparam logic [7:0]       RowBits8 = 8'(RowBits);
  localparam logic [AddrW-1:0] LastRow  = AddrW'(ROWS - 1);
  localparam logic [ModW-1:0]  LastMod  = ModW'(MODULES - 1);
  localparam logic [ClrW-1:0]  ClrRows  = ClrW'(ROWS);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEND   = 3'b010,
    ST_SCROLL = 3'b100
  } state_e;

  // what the send sequencer builds for each word
  typedef enum logic [1:0] {
    KIND_CONST,
    KIND_ROW,
    KIND_WRITE,
    KIND_READ
  } kind_e;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  logic [15:0]      word_q, word_d;
  logic             done_q, done_d;
  logic             ok_q, ok_d;
  logic [7:0]       addr_q, addr_d;
  logic [ModW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] sc_q, sc_d;
  logic [7:0]       amount_q, amount_d;

  // init and refresh sequencing state
  logic [2:0]       phase_q, phase_d;
  logic [ClrW-1:0]  clr_q, clr_d;
  logic [AddrW-1:0] refresh_q, refresh_d;

  logic [3:0] brightness_q;
  logic [2:0] scan_limit_q;

  // frame buffer ports
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [RowBits-1:0] ram_wdata, ram_rdata, row_eff;
  logic [ROWS-1:0]    row_valid_q, row_valid_d;
  logic               rd_valid_q;

  // output register
  logic        out_valid_q;
  logic [15:0] out_word_q;
  logic        out_spi_valid_q, out_last_q, out_done_q, out_ok_q;
  logic [31:0] out_rv_q;

  logic        in_ready, accept, out_free;
  logic        row_ok_in;
  logic [AddrW-1:0] row_idx;

  // word under construction
  logic        w_load;
  logic [15:0] w_word;
  logic        w_spi_valid, w_last;
  logic [31:0] w_rv;

  lmfr_ram #(
    .Width (RowBits),
    .Depth (ROWS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // rows never written read as zero
  assign row_eff = rd_valid_q ? ram_rdata : '0;

  assign in_ready  = (state_q == ST_IDLE);
  assign accept    = req_i.valid && in_ready;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign row_ok_in = (req_i.row < 4'(ROWS));
  assign row_idx   = req_i.row[AddrW-1:0];

  assign req_i.ready = in_ready;

  // word assembly for the send sequencer
  always_comb begin
    logic [7:0] byte_k;
    byte_k      = row_eff[8*cnt_q +: 8];
    w_word      = '0;
    w_spi_valid = 1'b0;
    w_last      = 1'b1;
    w_rv        = '0;
    case (kind_q)
      KIND_CONST: begin
        w_word      = word_q;
        w_spi_valid = 1'b1;
        w_last      = (cnt_q == LastMod);
      end
      KIND_ROW: begin
        w_word      = {addr_q, rev8(byte_k)};
        w_spi_valid = 1'b1;
        w_last      = (cnt_q == LastMod);
      end
      KIND_READ: begin
        // module byte k of the stored row goes back to its write position
        if (ok_q) begin
          for (int k = 0; k < MODULES; k++) begin
            w_rv = w_rv | (32'({24'd0, row_eff[8*k +: 8]}) << (8 * (MODULES - 1 - k)));
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign w_load = (state_q == ST_SEND) && out_free;

  // main control
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    word_d      = word_q;
    done_d      = done_q;
    ok_d        = ok_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    sc_d        = sc_q;
    amount_d    = amount_q;
    phase_d     = phase_q;
    clr_d       = clr_q;
    refresh_d   = refresh_q;
    row_valid_d = row_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d  = '0;
          done_d = 1'b0;
          ok_d   = 1'b0;
          case (req_i.cmd)
            CMD_INIT: begin
              state_d = ST_SEND;
              kind_d  = KIND_CONST;
              case (phase_q)
                PH_CLEAR: begin
                  if (clr_q < ClrRows) begin
                    word_d = {8'(clr_q) + 8'd1, 8'd0};
                    clr_d  = clr_q + 1'b1;
                  end else begin
                    // silent step: no words, move on to decode off
                    clr_d   = '0;
                    phase_d = PH_DECODE;
                    state_d = ST_IDLE;
                  end
                end
                PH_DECODE: begin
                  word_d  = W_DECODE_OFF;
                  phase_d = PH_SCAN;
                end
                PH_SCAN: begin
                  word_d  = W_SCAN | {13'd0, scan_limit_q};
                  phase_d = PH_BRIGHT;
                end
                PH_BRIGHT: begin
                  word_d  = W_BRIGHT | {12'd0, brightness_q};
                  phase_d = PH_COPY;
                end
                PH_COPY: begin
                  // frame copy shares the refresh row counter
                  kind_d    = KIND_ROW;
                  ram_re    = 1'b1;
                  ram_raddr = refresh_q;
                  addr_d    = 8'(ROWS) - 8'(refresh_q);
                  if (refresh_q == LastRow) begin
                    refresh_d = '0;
                    phase_d   = PH_WAKE;
                  end else begin
                    refresh_d = refresh_q + 1'b1;
                  end
                end
                PH_WAKE: begin
                  word_d  = W_WAKE;
                  done_d  = 1'b1;
                  phase_d = PH_SHUTDOWN;
                end
                default: begin
                  word_d  = W_SHUTDOWN;
                  phase_d = PH_CLEAR;
                end
              endcase
            end
            CMD_REFRESH: begin
              state_d   = ST_SEND;
              kind_d    = KIND_ROW;
              ram_re    = 1'b1;
              ram_raddr = refresh_q;
              addr_d    = 8'(ROWS) - 8'(refresh_q);
              if (refresh_q == LastRow) begin
                refresh_d = '0;
                done_d    = 1'b1;
              end else begin
                refresh_d = refresh_q + 1'b1;
              end
            end
            CMD_SCROLL: begin
              state_d   = ST_SCROLL;
              amount_d  = req_i.amount;
              sc_d      = '0;
              ram_re    = 1'b1;
              ram_raddr = '0;
            end
            CMD_WRITE: begin
              state_d = ST_SEND;
              kind_d  = KIND_WRITE;
              ok_d    = row_ok_in;
              if (row_ok_in) begin
                ram_we    = 1'b1;
                ram_waddr = row_idx;
                // most significant request byte lands in module slot 0
                for (int k = 0; k < MODULES; k++) begin
                  ram_wdata[8*k +: 8] = 8'(req_i.row_data >> (8 * (MODULES - 1 - k)));
                end
                row_valid_d[row_idx] = 1'b1;
              end
            end
            CMD_READ: begin
              state_d   = ST_SEND;
              kind_d    = KIND_READ;
              ok_d      = row_ok_in;
              ram_re    = 1'b1;
              ram_raddr = row_idx;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEND: begin
        if (out_free) begin
          if (w_last) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_SCROLL: begin
        // read row sc+1 while writing back the shifted row sc
        ram_we    = 1'b1;
        ram_waddr = sc_q;
        ram_wdata = (amount_q >= RowBits8) ? '0 : (row_eff << amount_q);
        row_valid_d[sc_q] = 1'b1;
        if (sc_q == LastRow) begin
          state_d = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = sc_q + 1'b1;
          sc_d      = sc_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_SHUTDOWN;
      clr_q        <= '0;
      refresh_q    <= '0;
      row_valid_q  <= '0;
      rd_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      brightness_q <= BRIGHTNESS_RST;
      scan_limit_q <= SCAN_LIMIT_RST;
      cnt_q        <= '0;
      sc_q         <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      clr_q       <= clr_d;
      refresh_q   <= refresh_d;
      row_valid_q <= row_valid_d;
      cnt_q       <= cnt_d;
      sc_q        <= sc_d;
      if (ram_re) begin
        rd_valid_q <= row_valid_q[ram_raddr];
      end
      if (w_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BRIGHTNESS: brightness_q <= cfg_data_i;
          CFG_SCAN_LIMIT: scan_limit_q <= cfg_data_i[2:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    word_q   <= word_d;
    done_q   <= done_d;
    ok_q     <= ok_d;
    addr_q   <= addr_d;
    amount_q <= amount_d;
    if (w_load) begin
      out_word_q      <= w_word;
      out_spi_valid_q <= w_spi_valid;
      out_last_q      <= w_last;
      out_done_q      <= done_q;
      out_rv_q        <= w_rv;
      out_ok_q        <= ok_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.spi_word      = out_word_q;
  assign rsp_o.spi_valid     = out_spi_valid_q;
  assign rsp_o.last_word     = out_last_q;
  assign rsp_o.sequence_done = out_done_q;
  assign rsp_o.read_value    = out_rv_q;
  assign rsp_o.row_ok        = out_ok_q;

endmodule

// File: rtl/lmfr_ram.sv
module lmfr_ram #(
  parameter int Width = 32,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: tb/sv/led_matrix_frame_refresher_unit_test.sv
`timescale 1ns / 1ps

module led_matrix_frame_refresher_unit_test;
  import lmfr_pkg::*;

  localparam int ROWS    = 8;
  localparam int MODULES = 4;
  // enough quiet cycles for a scroll walk or a silent init step to finish
  localparam int SETTLE_CYCLES = ROWS + 8;
  // a full init run: shutdown, clears, silent step, decode, scan, brightness, copy, wake
  localparam int INIT_RUN_LEN = 1 + ROWS + 1 + 3 + ROWS + 1;

  // command codes the block ignores
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  // one serial word (or write/read status) leaving the block
  typedef struct packed {
    logic [15:0] spi_word;
    logic        spi_valid;
    logic        last_word;
    logic        sequence_done;
    logic [31:0] read_value;
    logic        row_ok;
  } spi_out_t;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  cfg_idx_t  cfg_idx_i;
  cfg_data_t cfg_data_i;

  lmfr_req_if req_if ();
  lmfr_rsp_if rsp_if ();

  led_matrix_frame_refresher_unit #(
    .ROWS    (ROWS),
    .MODULES (MODULES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow copy of the block state, updated when a request is taken
  logic [31:0] frame_mem [ROWS];
  logic [2:0]  init_ph;
  logic [3:0]  clear_cnt;
  logic [2:0]  row_ptr;
  logic [3:0]  bright_val;
  logic [2:0]  scan_val;

  // words still owed by the block, oldest first
  spi_out_t spi_out_q [$];

  int errors;
  bit steady_sink;  // sink never stalls while set
  bit no_gaps;      // source sends back to back while set

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 80) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_word(logic [15:0] w, logic v, logic last, logic done,
                                    logic [31:0] rv, logic ok);
    spi_out_t e;
    e.spi_word      = w;
    e.spi_valid     = v;
    e.last_word     = last;
    e.sequence_done = done;
    e.read_value    = rv;
    e.row_ok        = ok;
    spi_out_q.push_back(e);
  endfunction

  // same command word to every chip in the chain
  function automatic void push_broadcast(logic [15:0] w, logic done);
    for (int k = 0; k < MODULES; k++) begin
      push_word(w, 1'b1, k == MODULES - 1, done, 32'd0, 1'b0);
    end
  endfunction

  // one frame row, mirrored vertically and bit reversed per chip;
  // returns 1 when the bottom row went out and the pointer wrapped
  function automatic bit push_row_words(logic flag_done);
    logic [2:0] r;
    logic [7:0] addr;
    logic [7:0] b;
    logic [7:0] m;
    bit         fin;
    r    = row_ptr;
    fin  = (int'(r) + 1 >= ROWS);
    addr = 8'(ROWS) - {5'd0, r};
    row_ptr = fin ? 3'd0 : r + 3'd1;
    for (int k = 0; k < MODULES; k++) begin
      b = frame_mem[r][8*k +: 8];
      for (int i = 0; i < 8; i++) begin
        m[7-i] = b[i];
      end
      push_word({addr, m}, 1'b1, k == MODULES - 1, flag_done && fin, 32'd0, 1'b0);
    end
    return fin;
  endfunction

  // advance the shadow state for one taken request and queue the words it owes
  function automatic void compute_spi_words(logic [2:0] cmd, logic [3:0] row,
                                            logic [31:0] data, logic [7:0] amount);
    logic        ok;
    logic [31:0] s;
    logic [31:0] v;
    ok = (int'(row) < ROWS);
    case (cmd)
      CMD_INIT: begin
        case (init_ph)
          PH_CLEAR: begin
            if (int'(clear_cnt) < ROWS) begin
              push_broadcast({8'(clear_cnt) + 8'd1, 8'h00}, 1'b0);
              clear_cnt = clear_cnt + 4'd1;
            end else begin
              // one silent step closes the clear phase
              clear_cnt = 4'd0;
              init_ph   = PH_DECODE;
            end
          end
          PH_DECODE: begin
            init_ph = PH_SCAN;
            push_broadcast(W_DECODE_OFF, 1'b0);
          end
          PH_SCAN: begin
            init_ph = PH_BRIGHT;
            push_broadcast(W_SCAN | {13'd0, scan_val}, 1'b0);
          end
          PH_BRIGHT: begin
            init_ph = PH_COPY;
            push_broadcast(W_BRIGHT | {12'd0, bright_val}, 1'b0);
          end
          PH_COPY: begin
            // frame copy shares the refresh row pointer, no done flag here
            if (push_row_words(1'b0)) init_ph = PH_WAKE;
          end
          PH_WAKE: begin
            init_ph = PH_SHUTDOWN;
            push_broadcast(W_WAKE, 1'b1);
          end
          default: begin
            init_ph = PH_CLEAR;
            push_broadcast(W_SHUTDOWN, 1'b0);
          end
        endcase
      end
      CMD_REFRESH: begin
        void'(push_row_words(1'b1));
      end
      CMD_SCROLL: begin
        for (int r = 0; r < ROWS; r++) begin
          if (int'(amount) >= 8 * MODULES) frame_mem[r] = 32'd0;
          else frame_mem[r] = frame_mem[r] << amount;
        end
      end
      CMD_WRITE: begin
        // top byte of the request lands in the first chip slot
        if (ok) frame_mem[row[2:0]] = {data[7:0], data[15:8], data[23:16], data[31:24]};
        push_word(16'd0, 1'b0, 1'b1, 1'b0, 32'd0, ok);
      end
      CMD_READ: begin
        s = frame_mem[row[2:0]];
        v = ok ? {s[7:0], s[15:8], s[23:16], s[31:24]} : 32'd0;
        push_word(16'd0, 1'b0, 1'b1, 1'b0, v, ok);
      end
      default: begin
        // unused codes are dropped
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  // compare every word the sink takes with the oldest one owed
  always @(posedge clk_i) begin : check_words
    spi_out_t e;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (spi_out_q.size() == 0) begin
        $error("spi_word: expected none, got %h", rsp_if.spi_word);
        errors++;
      end else begin
        e = spi_out_q.pop_front();
        check_field("spi_word", 32'(e.spi_word), 32'(rsp_if.spi_word));
        check_field("spi_valid", 32'(e.spi_valid), 32'(rsp_if.spi_valid));
        check_field("last_word", 32'(e.last_word), 32'(rsp_if.last_word));
        check_field("sequence_done", 32'(e.sequence_done), 32'(rsp_if.sequence_done));
        check_field("read_value", e.read_value, rsp_if.read_value);
        check_field("row_ok", 32'(e.row_ok), 32'(rsp_if.row_ok));
      end
    end
  end

  // sink side: runs of ready broken by stalls of random length
  initial begin : sink_pacing
    int run;
    run = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (steady_sink) begin
        rsp_if.ready = 1'b1;
      end else if (run > 0) begin
        run--;
      end else if (rsp_if.ready && $urandom_range(99) < 40) begin
        rsp_if.ready = 1'b0;
        run = pick_gap() - 1;
      end else begin
        rsp_if.ready = 1'b1;
        run = $urandom_range(0, 30);
      end
    end
  end

  // present one request and hold it until the block takes it
  task automatic send_request(input logic [2:0] cmd, input logic [3:0] row,
                              input logic [31:0] data, input logic [7:0] amount);
    int gap;
    gap = (no_gaps || $urandom_range(99) < 50) ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.cmd      = cmd;
    req_if.row      = row;
    req_if.row_data = data;
    req_if.amount   = amount;
    req_if.valid    = 1'b1;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    compute_spi_words(cmd, row, data, amount);
  endtask

  // stop sending until every owed word is out and the block has settled
  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (spi_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_t idx, input cfg_data_t data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_BRIGHTNESS) bright_val = data;
    else scan_val = data[2:0];
  endtask

  // row writes and reads, both legal and out of range rows, plus ignored codes
  task automatic test_row_access();
    send_request(CMD_WRITE, 4'd0, 32'hFFFF_FFFF, 8'd0);
    send_request(CMD_WRITE, 4'd7, 32'h1234_5678, 8'hFF);
    send_request(CMD_WRITE, 4'd8, 32'hDEAD_BEEF, 8'd0);
    send_request(CMD_WRITE, 4'd15, 32'h0000_0000, 8'd0);
    send_request(CMD_UNUSED_LO, 4'd1, 32'hFFFF_FFFF, 8'hFF);
    send_request(CMD_READ, 4'd0, 32'd0, 8'd0);
    send_request(CMD_READ, 4'd7, 32'd0, 8'd0);
    send_request(CMD_READ, 4'd8, 32'd0, 8'd0);
    send_request(CMD_READ, 4'd15, 32'd0, 8'd0);
    send_request(CMD_UNUSED_HI, 4'd7, 32'd0, 8'd0);
  endtask

  // shifts of zero, one, just below the row width, the row width and the maximum
  task automatic test_scroll_shift();
    send_request(CMD_WRITE, 4'd3, 32'h8000_0001, 8'd0);
    send_request(CMD_SCROLL, 4'd0, 32'd0, 8'd0);
    send_request(CMD_READ, 4'd3, 32'd0, 8'd0);
    send_request(CMD_SCROLL, 4'd0, 32'd0, 8'd1);
    send_request(CMD_READ, 4'd3, 32'd0, 8'd0);
    send_request(CMD_SCROLL, 4'd0, 32'd0, 8'd31);
    send_request(CMD_READ, 4'd3, 32'd0, 8'd0);
    send_request(CMD_WRITE, 4'd3, 32'hA5C3_0FF0, 8'd0);
    send_request(CMD_SCROLL, 4'd0, 32'd0, 8'd32);
    send_request(CMD_READ, 4'd3, 32'd0, 8'd0);
    send_request(CMD_WRITE, 4'd5, 32'h0102_0408, 8'd0);
    send_request(CMD_SCROLL, 4'd0, 32'd0, 8'hFF);
    send_request(CMD_READ, 4'd5, 32'd0, 8'd0);
    send_request(CMD_REFRESH, 4'd0, 32'd0, 8'd0);
    send_request(CMD_REFRESH, 4'd0, 32'd0, 8'd0);
  endtask

  // new settings on an idle block, then a whole init run from shutdown to wake-up
  task automatic test_init_sequence(input cfg_data_t bright, input cfg_data_t scan,
                                    input bit steady);
    wait_idle();
    write_register(CFG_BRIGHTNESS, bright);
    write_register(CFG_SCAN_LIMIT, scan);
    // finish whatever init run random traffic left half done
    while (init_ph != PH_SHUTDOWN) send_request(CMD_INIT, 4'd0, 32'd0, 8'd0);
    // fill a few rows so the frame copy carries real data
    for (int r = 0; r < ROWS; r += 3) begin
      send_request(CMD_WRITE, 4'(r), $urandom, 8'd0);
    end
    steady_sink = steady;
    no_gaps     = steady;
    for (int i = 0; i < INIT_RUN_LEN; i++) begin
      send_request(CMD_INIT, 4'(i), 32'd0, 8'd0);
    end
    steady_sink = 1'b0;
    no_gaps     = 1'b0;
  endtask

  // mixed traffic, weighted toward init steps so runs go through every phase
  task automatic test_random_traffic(input int count);
    logic [2:0]  cmd;
    logic [3:0]  row;
    logic [31:0] data;
    logic [7:0]  amount;
    int          p;
    int          sent;
    sent = 0;
    while (sent < count) begin
      p = $urandom_range(99);
      if (p < 38) cmd = CMD_INIT;
      else if (p < 55) cmd = CMD_REFRESH;
      else if (p < 64) cmd = CMD_SCROLL;
      else if (p < 81) cmd = CMD_WRITE;
      else if (p < 97) cmd = CMD_READ;
      else cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      row = ($urandom_range(99) < 80) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(8, 15));
      p = $urandom_range(99);
      if (p < 10) data = 32'd0;
      else if (p < 20) data = 32'hFFFF_FFFF;
      else data = $urandom;
      p = $urandom_range(99);
      if (p < 70) amount = 8'($urandom_range(0, 7));
      else if (p < 90) amount = 8'($urandom_range(8, 40));
      else amount = 8'($urandom_range(0, 255));
      send_request(cmd, row, data, amount);
      if (cmd <= CMD_READ) sent++;
    end
  endtask

  initial begin
    // everything known from time zero, with reset held low at first
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_BRIGHTNESS;
    cfg_data_i      = '0;
    req_if.valid    = 1'b0;
    req_if.cmd      = CMD_INIT;
    req_if.row      = '0;
    req_if.row_data = '0;
    req_if.amount   = '0;
    errors      = 0;
    steady_sink = 1'b0;
    no_gaps     = 1'b0;
    for (int r = 0; r < ROWS; r++) frame_mem[r] = 32'd0;
    init_ph    = PH_SHUTDOWN;
    clear_cnt  = 4'd0;
    row_ptr    = 3'd0;
    bright_val = BRIGHTNESS_RST;
    scan_val   = SCAN_LIMIT_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_row_access();
    test_scroll_shift();
    test_init_sequence(4'd15, 4'd0, 1'b0);
    test_random_traffic(30);
    test_init_sequence(4'd0, 4'd7, 1'b1);
    test_random_traffic(30);
    test_init_sequence(cfg_data_t'($urandom_range(15)), cfg_data_t'($urandom_range(7)), 1'b0);
    test_random_traffic(30);
    test_init_sequence(4'd15, 4'd7, 1'b0);
    test_random_traffic(30);

    // all requests taken: let the last words drain before judging
    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
